// ===== rtl/core/rmth_pkg.sv =====
// Package for the running median block: heap command/status types, state enums
// and the heap ordering function. No dependencies.
package rmth_pkg;

    typedef enum logic {
        HOP_PUSH,
        HOP_REPLACE
    } heap_op_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_UP,
        HS_DOWN,
        HS_FIN
    } heap_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic               start;
        heap_op_t           op;
        logic signed [31:0] value;
    } heap_cmd_t;

    typedef struct packed {
        logic               busy;
        logic signed [31:0] top;
    } heap_stat_t;

    function automatic logic ranks_above(logic signed [31:0] a, logic signed [31:0] b,
                                         logic is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

endpackage

// ===== rtl/core/rmth_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 514
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== rtl/core/rmth_heap.sv =====
// One binary heap held in an rmth_ram, with push and replace-top operations,
// one level per cycle. Depends on rmth_pkg and rmth_ram.
module rmth_heap
    import rmth_pkg::*;
#(
    parameter int DEPTH  = 514,
    parameter bit IS_MAX = 1'b1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  heap_cmd_t                  cmd,
    output heap_stat_t                 stat,
    output logic [$clog2(DEPTH+1)-1:0] size
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;

    heap_state_t        state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic signed [31:0] val_reg, val_next;
    logic [SW-1:0]      size_reg, size_next;
    logic signed [31:0] top_reg;

    logic               we;
    logic [AW-1:0]      waddr, raddr0, raddr1;
    logic signed [31:0] wdata, rdata0, rdata1;

    logic [AW-1:0]      pidx;
    logic [XW-1:0]      lchild, rchild, csel, gl, size_x;
    logic               lv, rv, pick_r;
    logic signed [31:0] cval;

    rmth_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
        if (we && waddr == '0)
        begin
            top_reg <= wdata;
        end
    end

    always_comb
    begin
        pidx   = AW'((idx_reg - 1'b1) >> 1);
        size_x = XW'(size_reg);
        lchild = {1'b0, idx_reg, 1'b1};
        rchild = lchild + 1'b1;
        lv     = lchild < size_x;
        rv     = rchild < size_x;
        pick_r = rv && ranks_above(rdata1, rdata0, IS_MAX);
        csel   = pick_r ? rchild : lchild;
        cval   = pick_r ? rdata1 : rdata0;
        gl     = {csel[XW-2:0], 1'b1};

        state_next = state_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        size_next  = size_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = val_reg;
        raddr0     = pidx;
        raddr1     = pidx;

        unique case (state_reg)
            HS_IDLE:
            begin
                if (cmd.start)
                begin
                    val_next = cmd.value;
                    if (cmd.op == HOP_PUSH)
                    begin
                        size_next = size_reg + 1'b1;
                        idx_next  = AW'(size_reg);
                        raddr0    = AW'((size_reg - 1'b1) >> 1);
                        state_next = (size_reg == '0) ? HS_FIN : HS_UP;
                    end
                    else
                    begin
                        idx_next   = '0;
                        raddr0     = AW'(1);
                        raddr1     = AW'(2);
                        state_next = HS_DOWN;
                    end
                end
            end
            HS_UP:
            begin
                we = 1'b1;
                if (ranks_above(val_reg, rdata0, IS_MAX))
                begin
                    wdata    = rdata0;
                    idx_next = pidx;
                    raddr0   = AW'((pidx - 1'b1) >> 1);
                    if (pidx == '0)
                    begin
                        state_next = HS_FIN;
                    end
                end
                else
                begin
                    state_next = HS_IDLE;
                end
            end
            HS_DOWN:
            begin
                we = 1'b1;
                if (lv && ranks_above(cval, val_reg, IS_MAX))
                begin
                    wdata    = cval;
                    idx_next = AW'(csel);
                    raddr0   = AW'(gl);
                    raddr1   = AW'(gl + 1'b1);
                end
                else
                begin
                    state_next = HS_IDLE;
                end
            end
            HS_FIN:
            begin
                we         = 1'b1;
                state_next = HS_IDLE;
            end
            default:
            begin
                state_next = HS_IDLE;
            end
        endcase
    end

    assign stat.busy = (state_reg != HS_IDLE);
    assign stat.top  = top_reg;
    assign size      = size_reg;

`ifndef NO_ASSERTIONS
    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(size_reg) <= DEPTH)
        else $error("heap size beyond depth");
    a_size_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != HS_IDLE |=> $stable(size_reg))
        else $error("heap size moved during an operation");
    a_top_track: assert property (@(posedge clk) disable iff (!rst_n)
        we && waddr == '0 |=> top_reg == $past(wdata))
        else $error("cached top not updated on root write");
`endif

endmodule

// ===== rtl/core/running_median_two_heaps.sv =====
// Running median top level: controller over a max-heap (lower) and a min-heap (upper).
// Depends on rmth_pkg and rmth_heap.
//
//   channel  direction  signals
//   sample   in         sample_valid, sample_ready, sample
//   result   out        result_valid, result_ready, median_doubled, element_count, full_drop
//
// One word at a time. Each word needs at most one push on one heap and one top
// replacement on the other, run in parallel at one heap level per cycle. The result
// is valid once both heaps are idle, so its delay is set by the heap sift depth;
// a new word is taken only after the result of the last one has been taken.
// A dropped word starts no heap operation and goes from ST_RUN straight to ST_OUT. Reset clears the heap
// sizes; no clearing pass. sample_ready is low from accept until the result is taken.
module running_median_two_heaps
    import rmth_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  logic signed [31:0] sample,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [32:0] median_doubled,
    output logic [10:0]        element_count,
    output logic               full_drop
);

    localparam int DEPTH = CAPACITY / 2 + 2;
    localparam int SW    = $clog2(DEPTH + 1);

    ctl_state_t         state_reg, state_next;
    heap_cmd_t          lo_cmd, up_cmd;
    heap_stat_t         lo_stat, up_stat;
    logic [SW-1:0]      lo_size, up_size;
    logic [31:0]        count;
    logic               full, even;
    logic               drop_reg, drop_next;
    logic signed [32:0] med_reg, med_next;
    logic [10:0]        cnt_reg;
    logic               take;

    rmth_heap #(.DEPTH(DEPTH), .IS_MAX(1'b1)) u_lower (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (lo_cmd),
        .stat (lo_stat),
        .size (lo_size)
    );

    rmth_heap #(.DEPTH(DEPTH), .IS_MAX(1'b0)) u_upper (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (up_cmd),
        .stat (up_stat),
        .size (up_size)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drop_reg <= drop_next;
        med_reg  <= med_next;
        if (state_reg == ST_RUN)
        begin
            cnt_reg <= count[10:0];
        end
    end

    always_comb
    begin
        count = 32'(lo_size) + 32'(up_size);
        full  = count >= 32'(CAPACITY);
        even  = (lo_size == up_size);
        take  = sample_valid && (state_reg == ST_IDLE);

        state_next = state_reg;
        drop_next  = drop_reg;
        med_next   = med_reg;
        lo_cmd     = '{start: 1'b0, op: HOP_PUSH, value: sample};
        up_cmd     = '{start: 1'b0, op: HOP_PUSH, value: sample};

        if (count == '0)
        begin
            med_next = '0;
        end
        else if (!even)
        begin
            med_next = 33'(lo_stat.top) <<< 1;
        end
        else
        begin
            med_next = 33'(lo_stat.top) + 33'(up_stat.top);
        end
        if (state_reg != ST_RUN)
        begin
            med_next = med_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    drop_next  = full;
                    state_next = ST_RUN;
                    if (!full)
                    begin
                        if (even)
                        begin
                            if (up_size == '0 || sample <= up_stat.top)
                            begin
                                lo_cmd.start = 1'b1;
                            end
                            else
                            begin
                                up_cmd.start = 1'b1;
                                up_cmd.op    = HOP_REPLACE;
                                lo_cmd.start = 1'b1;
                                lo_cmd.value = up_stat.top;
                            end
                        end
                        else
                        begin
                            if (sample >= lo_stat.top)
                            begin
                                up_cmd.start = 1'b1;
                            end
                            else
                            begin
                                lo_cmd.start = 1'b1;
                                lo_cmd.op    = HOP_REPLACE;
                                up_cmd.start = 1'b1;
                                up_cmd.value = lo_stat.top;
                            end
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (!lo_stat.busy && !up_stat.busy)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    med_next = med_reg;
                end
            end
            ST_OUT:
            begin
                if (result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign sample_ready   = (state_reg == ST_IDLE);
    assign result_valid   = (state_reg == ST_OUT);
    assign median_doubled = med_reg;
    assign element_count  = cnt_reg;
    assign full_drop      = drop_reg;

`ifndef NO_ASSERTIONS
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> (lo_size == up_size || lo_size == up_size + 1'b1))
        else $error("heap sizes out of balance");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (lo_stat.busy || up_stat.busy) |-> state_reg == ST_RUN)
        else $error("heap busy outside run state");
    a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && full_drop |-> count == 32'(CAPACITY))
        else $error("drop flagged below capacity");
`endif

endmodule
